### hw/rtl/bpc_pkg.sv
// Shared types, constants and helper functions for the button press classifier.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CFG_WIDTH = 16;
   localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int NUM_BUTTONS = 3;
   localparam int NUM_VOL_KEYS = 2;
   localparam int PAIR_BUTTON = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = CFG_WIDTH'(50);
   localparam logic [CFG_WIDTH-1:0] SHORT_RESET = CFG_WIDTH'(500);
   localparam logic [CFG_WIDTH-1:0] REPEAT_RESET = CFG_WIDTH'(500);

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEBOUNCE = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHORT = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REPEAT = CSR_INDEX_WIDTH'(2);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CFG_WIDTH-1:0] cfg_word_type;

   typedef struct packed {
      cfg_word_type debounce_ticks;
      cfg_word_type short_press_ticks;
      cfg_word_type repeat_ticks;
   } cfg_type;

   typedef struct packed {
      logic vol_up_press;
      logic vol_down_press;
      logic pair_short;
      logic pair_long;
   } event_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
   endfunction

   function automatic logic [CMP_WIDTH-1:0] cnt_ext(input count_type v);
      return CMP_WIDTH'(v);
   endfunction

   function automatic logic [CMP_WIDTH-1:0] cfg_ext(input cfg_word_type v);
      return CMP_WIDTH'(v);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/button_press_classifier.sv
// Top level of the button press classifier: input register, core and result register.
// Path: a beat passes the input register, then the result register that drives rsp_valid.
// Throughput: one tick beat per cycle unless stalled; the counters update in one pass.
// Backpressure: a stalled result holds the pipe; the input register still takes one beat.
// Reset: levels read as released, counters and repeat timers clear, registers take
// their default times (debounce 50, short press 500, repeat 500).
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier
   import bpc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_vol_up_level,
   input  wire logic                       req_vol_down_level,
   input  wire logic                       req_pair_level,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_vol_up_press,
   output logic                            rsp_vol_down_press,
   output logic                            rsp_pair_short,
   output logic                            rsp_pair_long,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0]       csr_wdata
);

   cfg_type                cfg;
   event_type              events;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [NUM_BUTTONS-1:0] in_levels_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   event_type              rsp_event_ff;
   logic                   advance;
   logic                   step;
   logic                   req_accept;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign step = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_levels_ff <= {req_pair_level, req_vol_down_level, req_vol_up_level};
      end
      if (step) begin
         rsp_event_ff <= events;
      end
   end

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .levels (in_levels_ff),
      .cfg    (cfg),
      .events (events)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vol_up_press = rsp_event_ff.vol_up_press;
   assign rsp_vol_down_press = rsp_event_ff.vol_down_press;
   assign rsp_pair_short = rsp_event_ff.pair_short;
   assign rsp_pair_long = rsp_event_ff.pair_long;

   // The pair button ends a press as either short or long, never both.
   a_pair_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pair_short && rsp_pair_long))
      else $error("pair short and long press on the same beat");

   // An accepted beat always lands in the input register.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted beat lost at the input register");

   // A processed beat always produces a result on the next cycle.
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("processed beat produced no result");

endmodule

`default_nettype wire

### hw/rtl/bpc_csr.sv
// Configuration register file for the debounce, short-press and repeat times.
`timescale 1ns / 1ps
`default_nettype none

module bpc_csr
   import bpc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0]       csr_wdata,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DEBOUNCE: cfg_in.debounce_ticks = csr_wdata;
            REG_SHORT:    cfg_in.short_press_ticks = csr_wdata;
            REG_REPEAT:   cfg_in.repeat_ticks = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.short_press_ticks <= SHORT_RESET;
         cfg_ff.repeat_ticks <= REPEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/bpc_core.sv
// Per-button hold counters, per volume key repeat counters and the press classification logic.
`timescale 1ns / 1ps
`default_nettype none

module bpc_core
   import bpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [NUM_BUTTONS-1:0] levels,
   input  cfg_type                     cfg,
   output event_type                   events
);

   logic [NUM_BUTTONS-1:0]  last_levels_ff;
   count_type               hold_count_ff [NUM_BUTTONS];
   count_type               hold_count_in [NUM_BUTTONS];
   count_type               repeat_count_ff [NUM_VOL_KEYS];
   count_type               repeat_count_in [NUM_VOL_KEYS];
   logic [NUM_VOL_KEYS-1:0] repeat_active_ff;
   logic [NUM_VOL_KEYS-1:0] repeat_active_in;
   logic [NUM_BUTTONS-1:0]  short_ev;
   logic [NUM_VOL_KEYS-1:0] repeat_ev;
   logic                    long_ev;

   always_comb begin
      count_type held;
      count_type rcnt;
      logic      old_lvl;
      logic      new_lvl;
      rcnt = '0;
      short_ev = '0;
      long_ev = 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         old_lvl = last_levels_ff[i];
         new_lvl = levels[i];
         held = old_lvl ? hold_count_ff[i] : sat_inc(hold_count_ff[i]);
         hold_count_in[i] = held;
         if (new_lvl != old_lvl) begin
            if (!new_lvl) begin
               hold_count_in[i] = '0;
            end else if (cnt_ext(held) >= cfg_ext(cfg.debounce_ticks)) begin
               if (cnt_ext(held) <= cfg_ext(cfg.short_press_ticks)) begin
                  short_ev[i] = 1'b1;
               end else if (i == PAIR_BUTTON) begin
                  long_ev = 1'b1;
               end
            end
         end
      end

      repeat_ev = '0;
      for (int j = 0; j < NUM_VOL_KEYS; j++) begin
         old_lvl = last_levels_ff[j];
         new_lvl = levels[j];
         repeat_active_in[j] = repeat_active_ff[j];
         repeat_count_in[j] = repeat_count_ff[j];
         if (new_lvl != old_lvl) begin
            repeat_active_in[j] = !new_lvl;
            repeat_count_in[j] = '0;
         end else if (!new_lvl && repeat_active_ff[j]) begin
            rcnt = sat_inc(repeat_count_ff[j]);
            if (cnt_ext(rcnt) >= cfg_ext(cfg.repeat_ticks)) begin
               repeat_ev[j] = 1'b1;
               rcnt = '0;
            end
            repeat_count_in[j] = rcnt;
         end
      end
   end

   assign events.vol_up_press = short_ev[0] | repeat_ev[0];
   assign events.vol_down_press = short_ev[1] | repeat_ev[1];
   assign events.pair_short = short_ev[PAIR_BUTTON];
   assign events.pair_long = long_ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_levels_ff <= '1;
         repeat_active_ff <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            hold_count_ff[i] <= '0;
         end
         for (int j = 0; j < NUM_VOL_KEYS; j++) begin
            repeat_count_ff[j] <= '0;
         end
      end else if (step) begin
         last_levels_ff <= levels;
         repeat_active_ff <= repeat_active_in;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            hold_count_ff[i] <= hold_count_in[i];
         end
         for (int j = 0; j < NUM_VOL_KEYS; j++) begin
            repeat_count_ff[j] <= repeat_count_in[j];
         end
      end
   end

endmodule

`default_nettype wire
